// File: rtl/lset_pkg.sv
`default_nettype none
package lset_pkg;

  localparam int unsigned DEF_ENTRIES = 16;
  localparam int unsigned DEF_ID_BITS = 32;

  localparam int unsigned SEQ_ID_W  = 32;
  localparam int unsigned COUNT_W   = 29;
  localparam int unsigned MEM_OUT_W = 34;
  localparam int unsigned STAT_W    = 32;
  localparam int unsigned SMALL_W   = 5;
  localparam int unsigned MB_W      = 12;
  localparam int unsigned MB_SHIFT  = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned LIMIT_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MEMORY_MB = 2'd1;

  localparam logic [SMALL_W-1:0]   MAX_ENTRIES_RESET = 5'd16;
  localparam logic [COUNT_W-1:0]   COUNT_MAX         = {COUNT_W{1'b1}};
  localparam logic [MEM_OUT_W-1:0] MEM_OUT_MAX       = {MEM_OUT_W{1'b1}};

  typedef enum logic [2:0] {
    MODE_GET      = 3'd0,
    MODE_CONTAINS = 3'd1,
    MODE_PUT      = 3'd2,
    MODE_REMOVE   = 3'd3,
    MODE_APPEND   = 3'd4,
    MODE_CLEAR    = 3'd5,
    MODE_STATS    = 3'd6,
    MODE_NOP      = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_EVCHK,
    S_EVSCAN,
    S_FREESCAN,
    S_DONE
  } state_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] c);
    sat_inc = (c == {STAT_W{1'b1}}) ? c : c + STAT_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/lset_if.sv
`default_nettype none
interface lset_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] seq_id;
  logic [28:0] key_count;
  logic [28:0] value_count;
  modport source (output valid, mode, seq_id, key_count, value_count, input ready);
  modport sink   (input valid, mode, seq_id, key_count, value_count, output ready);
endinterface

interface lset_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [28:0] entry_key_count;
  logic [28:0] entry_value_count;
  logic [4:0]  entries_used;
  logic [33:0] memory_used;
  logic [4:0]  evicted_now;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  logic [31:0] reclaim_total;
  modport source (output valid, hit, entry_key_count, entry_value_count, entries_used,
                  memory_used, evicted_now, hit_total, miss_total, eviction_total,
                  reclaim_total, input ready);
  modport sink   (input valid, hit, entry_key_count, entry_value_count, entries_used,
                  memory_used, evicted_now, hit_total, miss_total, eviction_total,
                  reclaim_total, output ready);
endinterface

interface lset_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/lru_sized_entry_table.sv
// Channel   Direction  Handshake      Payload
// in_req    in         valid/ready    mode, seq_id, key_count, value_count
// out_rsp   out        valid/ready    hit, entry counts, usage, eviction and statistics
// cfg_req   in         valid/ready    index (0 max_entries, 1 max_memory_mb), data
//
// A request runs the id search over the table, then a sweep for the oldest entry for each
// eviction and, for an inserting put, a search for a free slot.
// Every step visits one table entry a cycle through the single sweep index.
// Reset (rst_n low, synchronous) empties the table and clears the statistics.
// A finished result waits in the output register; the next request is taken meanwhile.
// Configuration writes are always accepted.
`default_nettype none
module lru_sized_entry_table #(
  parameter int unsigned ENTRIES = lset_pkg::DEF_ENTRIES,
  parameter int unsigned ID_BITS = lset_pkg::DEF_ID_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lset_in_if.sink    in_req,
  lset_out_if.source out_rsp,
  lset_cfg_if.sink   cfg_req
);
  import lset_pkg::*;

  localparam int unsigned IDW = (ID_BITS < SEQ_ID_W) ? ID_BITS : SEQ_ID_W;
  localparam int unsigned RW  = $clog2(ENTRIES);
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned MW  = COUNT_W + 1 + $clog2(ENTRIES);
  localparam int unsigned OW  = (MW > MEM_OUT_W) ? MW : MEM_OUT_W;

  state_t state_r, state_nxt;

  logic                 valid_r [ENTRIES];
  logic [IDW-1:0]       id_r    [ENTRIES];
  logic [COUNT_W-1:0]   key_r   [ENTRIES];
  logic [COUNT_W-1:0]   val_r   [ENTRIES];
  logic [RW-1:0]        rank_r  [ENTRIES];

  logic [CW-1:0]        cnt_r;
  logic [MW-1:0]        mem_r;
  logic [STAT_W-1:0]    hit_cnt_r, miss_cnt_r, evict_cnt_r, reclaim_cnt_r;
  logic [SMALL_W-1:0]   max_entries_r;
  logic [MB_W-1:0]      max_mb_r;

  mode_t                mode_r;
  logic [IDW-1:0]       rid_r;
  logic [COUNT_W-1:0]   kin_r, vin_r;
  logic [RW-1:0]        idx_r, k_r;
  logic                 found_r, phase_r;
  logic [CW-1:0]        nev_r;

  logic                 out_valid_r;
  logic                 o_hit_r;
  logic [COUNT_W-1:0]   o_key_r, o_val_r;
  logic [SMALL_W-1:0]   o_used_r, o_nev_r;
  logic [MEM_OUT_W-1:0] o_mem_r;
  logic [STAT_W-1:0]    o_hit_tot_r, o_miss_tot_r, o_evict_tot_r, o_reclaim_tot_r;

  logic                 in_fire, last_idx, budget_hit, over_limit, victim, out_free;
  logic [COUNT_W:0]     need;
  logic [LIMIT_W-1:0]   limit_eff;
  logic [MW:0]          mem_need;
  logic [COUNT_W:0]     app_sum;
  logic [COUNT_W-1:0]   app_nk;
  logic [OW-1:0]        mem_ext;
  logic [CW+SMALL_W-1:0] cnt_ext, nev_ext;
  logic                 res_hit;
  logic [COUNT_W-1:0]   res_key, res_val;

  assign in_fire  = in_req.valid && in_req.ready;
  assign last_idx = (idx_r == RW'(ENTRIES - 1));
  assign out_free = !out_valid_r || out_rsp.ready;
  assign need     = (COUNT_W + 1)'(kin_r) + (COUNT_W + 1)'(vin_r);
  assign mem_need = (MW + 1)'(mem_r) + (MW + 1)'(need);

  always_comb begin
    if (max_entries_r == '0) begin
      limit_eff = LIMIT_W'(1);
    end else if (LIMIT_W'(max_entries_r) > LIMIT_W'(ENTRIES)) begin
      limit_eff = LIMIT_W'(ENTRIES);
    end else begin
      limit_eff = LIMIT_W'(max_entries_r);
    end
  end

  // Budget is MB times 2^18 elements; zero disables the check.
  assign budget_hit = (max_mb_r != '0) && (cnt_r != '0) &&
                      (mem_need > (MW + 1)'({max_mb_r, {MB_SHIFT{1'b0}}}));
  assign over_limit = LIMIT_W'(cnt_r) >= limit_eff;
  // Ranks of valid entries always form 0..cnt-1, so the oldest holds cnt-1.
  assign victim     = valid_r[idx_r] && (rank_r[idx_r] == RW'(cnt_r - CW'(1)));

  assign app_sum = (COUNT_W + 1)'(key_r[k_r]) + (COUNT_W + 1)'(kin_r);
  assign app_nk  = app_sum[COUNT_W] ? COUNT_MAX : app_sum[COUNT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_fire) state_nxt = S_SCAN;
      S_SCAN:     if (last_idx) state_nxt = S_EXEC;
      S_EXEC: begin
        if (mode_r == MODE_PUT && !found_r) begin
          state_nxt = S_EVCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVCHK: begin
        if (!phase_r && budget_hit) begin
          state_nxt = S_EVSCAN;
        end else if (!phase_r && over_limit) begin
          state_nxt = S_EVSCAN;
        end else begin
          state_nxt = S_FREESCAN;
        end
      end
      S_EVSCAN:   if (victim || last_idx) state_nxt = S_EVCHK;
      S_FREESCAN: if (!valid_r[idx_r] || last_idx) state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready  = (state_r == S_IDLE);
    cfg_req.ready = 1'b1;
  end

  always_comb begin
    res_hit = found_r && (mode_r == MODE_GET || mode_r == MODE_CONTAINS ||
                          mode_r == MODE_PUT || mode_r == MODE_REMOVE ||
                          mode_r == MODE_APPEND);
    res_key = '0;
    res_val = '0;
    if (res_hit && mode_r != MODE_REMOVE) begin
      res_key = key_r[k_r];
      res_val = val_r[k_r];
    end else if (mode_r == MODE_PUT) begin
      res_key = kin_r;
      res_val = vin_r;
    end
    mem_ext = OW'(mem_r);
    cnt_ext = (CW + SMALL_W)'(cnt_r);
    nev_ext = (CW + SMALL_W)'(nev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
      mem_r         <= '0;
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      evict_cnt_r   <= '0;
      reclaim_cnt_r <= '0;
      max_entries_r <= MAX_ENTRIES_RESET;
      max_mb_r      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_req.valid) begin
        if (cfg_req.index == CFG_MAX_ENTRIES) begin
          max_entries_r <= cfg_req.data[SMALL_W-1:0];
        end else if (cfg_req.index == CFG_MAX_MEMORY_MB) begin
          max_mb_r <= cfg_req.data[MB_W-1:0];
        end
      end

      if (out_valid_r && out_rsp.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r  <= mode_t'(in_req.mode);
            rid_r   <= in_req.seq_id[IDW-1:0];
            kin_r   <= in_req.key_count;
            vin_r   <= in_req.value_count;
            idx_r   <= '0;
            found_r <= 1'b0;
            phase_r <= 1'b0;
            nev_r   <= '0;
          end
        end
        S_SCAN: begin
          if (valid_r[idx_r] && id_r[idx_r] == rid_r) begin
            found_r <= 1'b1;
            k_r     <= idx_r;
          end
          idx_r <= idx_r + RW'(1);
        end
        S_EXEC: begin
          case (mode_r)
            MODE_GET: begin
              if (found_r) begin
                for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_r[i] && rank_r[i] < rank_r[k_r]) rank_r[i] <= rank_r[i] + RW'(1);
                end
                rank_r[k_r] <= '0;
                hit_cnt_r   <= sat_inc(hit_cnt_r);
              end else begin
                miss_cnt_r <= sat_inc(miss_cnt_r);
              end
            end
            MODE_PUT: begin
              if (found_r) begin
                for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_r[i] && rank_r[i] < rank_r[k_r]) rank_r[i] <= rank_r[i] + RW'(1);
                end
                rank_r[k_r] <= '0;
                key_r[k_r]  <= kin_r;
                val_r[k_r]  <= vin_r;
                mem_r <= mem_r - MW'(key_r[k_r]) - MW'(val_r[k_r]) + MW'(need);
              end
            end
            MODE_REMOVE: begin
              if (found_r) begin
                for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_r[i] && rank_r[i] > rank_r[k_r]) rank_r[i] <= rank_r[i] - RW'(1);
                end
                valid_r[k_r] <= 1'b0;
                cnt_r <= cnt_r - CW'(1);
                mem_r <= mem_r - MW'(key_r[k_r]) - MW'(val_r[k_r]);
              end
            end
            MODE_APPEND: begin
              if (found_r) begin
                key_r[k_r] <= app_nk;
                val_r[k_r] <= app_nk;
                mem_r <= mem_r - MW'(key_r[k_r]) - MW'(val_r[k_r])
                         + MW'(app_nk) + MW'(app_nk);
              end
            end
            MODE_CLEAR: begin
              for (int i = 0; i < ENTRIES; i++) begin
                valid_r[i] <= 1'b0;
              end
              cnt_r <= '0;
              mem_r <= '0;
            end
            MODE_STATS: begin
              hit_cnt_r     <= '0;
              miss_cnt_r    <= '0;
              evict_cnt_r   <= '0;
              reclaim_cnt_r <= '0;
            end
            default: ;
          endcase
        end
        S_EVCHK: begin
          idx_r <= '0;
          if (!phase_r && budget_hit) begin
            reclaim_cnt_r <= sat_inc(reclaim_cnt_r);
          end else if (!phase_r) begin
            phase_r <= 1'b1;
          end
        end
        S_EVSCAN: begin
          if (victim) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i] && rank_r[i] > rank_r[idx_r]) rank_r[i] <= rank_r[i] - RW'(1);
            end
            valid_r[idx_r] <= 1'b0;
            cnt_r       <= cnt_r - CW'(1);
            mem_r       <= mem_r - MW'(key_r[idx_r]) - MW'(val_r[idx_r]);
            nev_r       <= nev_r + CW'(1);
            evict_cnt_r <= sat_inc(evict_cnt_r);
          end
          idx_r <= idx_r + RW'(1);
        end
        S_FREESCAN: begin
          if (!valid_r[idx_r]) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i]) rank_r[i] <= rank_r[i] + RW'(1);
            end
            valid_r[idx_r] <= 1'b1;
            id_r[idx_r]    <= rid_r;
            key_r[idx_r]   <= kin_r;
            val_r[idx_r]   <= vin_r;
            rank_r[idx_r]  <= '0;
            cnt_r <= cnt_r + CW'(1);
            mem_r <= mem_r + MW'(need);
          end
          idx_r <= idx_r + RW'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            o_hit_r          <= res_hit;
            o_key_r          <= res_key;
            o_val_r          <= res_val;
            o_used_r         <= cnt_ext[SMALL_W-1:0];
            o_nev_r          <= nev_ext[SMALL_W-1:0];
            o_mem_r          <= (mem_ext > OW'(MEM_OUT_MAX)) ? MEM_OUT_MAX
                                                             : mem_ext[MEM_OUT_W-1:0];
            o_hit_tot_r      <= hit_cnt_r;
            o_miss_tot_r     <= miss_cnt_r;
            o_evict_tot_r    <= evict_cnt_r;
            o_reclaim_tot_r  <= reclaim_cnt_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_rsp.valid             = out_valid_r;
    out_rsp.hit               = o_hit_r;
    out_rsp.entry_key_count   = o_key_r;
    out_rsp.entry_value_count = o_val_r;
    out_rsp.entries_used      = o_used_r;
    out_rsp.memory_used       = o_mem_r;
    out_rsp.evicted_now       = o_nev_r;
    out_rsp.hit_total         = o_hit_tot_r;
    out_rsp.miss_total        = o_miss_tot_r;
    out_rsp.eviction_total    = o_evict_tot_r;
    out_rsp.reclaim_total     = o_reclaim_tot_r;
  end

endmodule
`default_nettype wire

// File: rtl/lset_checker.sv
`default_nettype none
module lset_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [4:0]  out_entries_used,
  input wire logic [4:0]  out_evicted_now
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // One request at a time: the block is busy in the cycle after it takes one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is still at work");

  // Requests that find their id never evict.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_evicted_now == 5'd0)
    else $error("eviction reported on a hit");

  // An eviction that leaves an empty table only comes with a new entry.
  a_evict_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_now != 5'd0 |-> out_entries_used != 5'd0)
    else $error("eviction reported without an inserted entry");

endmodule

bind lru_sized_entry_table lset_checker u_lset_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_hit          (out_rsp.hit),
  .out_entries_used (out_rsp.entries_used),
  .out_evicted_now  (out_rsp.evicted_now)
);
`default_nettype wire

// File: tb/lru_sized_entry_table_tb.sv
`default_nettype none
module lru_sized_entry_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lset_pkg::*;

  localparam int NSLOT = 16;
  localparam longint unsigned ELEMS_PER_MB = 262144;

  typedef struct {
    mode_t             mode;
    logic [31:0]       seq_id;
    logic [COUNT_W-1:0] key_count;
    logic [COUNT_W-1:0] value_count;
  } cache_req_t;

  typedef struct {
    logic                 hit;
    logic [COUNT_W-1:0]   entry_key_count;
    logic [COUNT_W-1:0]   entry_value_count;
    logic [4:0]           entries_used;
    logic [MEM_OUT_W-1:0] memory_used;
    logic [4:0]           evicted_now;
    logic [31:0]          hit_total;
    logic [31:0]          miss_total;
    logic [31:0]          eviction_total;
    logic [31:0]          reclaim_total;
  } cache_rsp_t;

  logic clk;
  logic rst_n;

  lset_in_if  in_if();
  lset_out_if out_if();
  lset_cfg_if cfg_if();

  lru_sized_entry_table u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_if),
    .out_rsp (out_if),
    .cfg_req (cfg_if)
  );

  // Shadow copy of the table, the statistics and the two registers.
  bit                 slot_valid [NSLOT];
  logic [31:0]        slot_id    [NSLOT];
  logic [COUNT_W-1:0] slot_keys  [NSLOT];
  logic [COUNT_W-1:0] slot_vals  [NSLOT];
  int                 slot_age   [NSLOT];
  longint unsigned    held_elems;
  logic [31:0]        hits_seen, misses_seen, evictions_seen, reclaims_seen;
  logic [4:0]         entry_limit_reg;
  logic [11:0]        budget_mb_reg;

  cache_req_t pending_reqs[$];
  cache_rsp_t expected_rsps[$];
  int         error_count;
  int         results_checked;
  int         budget_evictions;
  logic [31:0] id_pool [20];
  bit         no_gaps;
  bit         hold_go;
  int         hold_left;

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += slot_valid[i];
    return n;
  endfunction

  function automatic void resum_elems();
    held_elems = 0;
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i]) held_elems += longint'(slot_keys[i]) + longint'(slot_vals[i]);
  endfunction

  function automatic void make_newest(int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void free_slot(int s);
    int r;
    r = slot_age[s];
    slot_valid[s] = 0;
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
    slot_id[s] = '0;
    slot_keys[s] = '0;
    slot_vals[s] = '0;
    slot_age[s] = 0;
    resum_elems();
  endfunction

  function automatic int evict_oldest();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
    if (best < 0) return 0;
    free_slot(best);
    evictions_seen = bump(evictions_seen);
    return 1;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 0;
      slot_id[i] = '0;
      slot_keys[i] = '0;
      slot_vals[i] = '0;
      slot_age[i] = 0;
    end
    held_elems = 0;
  endfunction

  function automatic cache_rsp_t predict_lookup(cache_req_t rq);
    cache_rsp_t rs;
    int s, j, lim, nev;
    longint unsigned need, budget, grown;
    s = find_slot(rq.seq_id);
    nev = 0;
    rs = '{default: '0};
    rs.hit = (rq.mode inside {MODE_GET, MODE_CONTAINS, MODE_PUT, MODE_REMOVE, MODE_APPEND})
             && s >= 0;
    case (rq.mode)
      MODE_GET: begin
        if (s >= 0) begin
          make_newest(s);
          hits_seen = bump(hits_seen);
        end else begin
          misses_seen = bump(misses_seen);
        end
      end
      MODE_PUT: begin
        if (s >= 0) begin
          slot_keys[s] = rq.key_count;
          slot_vals[s] = rq.value_count;
          make_newest(s);
          resum_elems();
        end else begin
          need = longint'(rq.key_count) + longint'(rq.value_count);
          lim = entry_limit_reg;
          if (lim < 1) lim = 1;
          if (lim > NSLOT) lim = NSLOT;
          if (budget_mb_reg != 0) begin
            budget = longint'(budget_mb_reg) * ELEMS_PER_MB;
            while (held_elems + need > budget && live_slots() > 0) begin
              nev += evict_oldest();
              reclaims_seen = bump(reclaims_seen);
              budget_evictions++;
            end
          end
          if (live_slots() >= lim) nev += evict_oldest();
          for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i]) slot_age[i]++;
          for (int i = 0; i < NSLOT; i++) begin
            if (!slot_valid[i]) begin
              slot_valid[i] = 1;
              slot_id[i] = rq.seq_id;
              slot_keys[i] = rq.key_count;
              slot_vals[i] = rq.value_count;
              slot_age[i] = 0;
              break;
            end
          end
          resum_elems();
        end
      end
      MODE_REMOVE: if (s >= 0) free_slot(s);
      MODE_APPEND: begin
        if (s >= 0) begin
          grown = longint'(slot_keys[s]) + longint'(rq.key_count);
          if (grown > longint'(COUNT_MAX)) grown = longint'(COUNT_MAX);
          slot_keys[s] = grown[COUNT_W-1:0];
          slot_vals[s] = grown[COUNT_W-1:0];
          resum_elems();
        end
      end
      MODE_CLEAR: clear_table();
      MODE_STATS: begin
        hits_seen = '0;
        misses_seen = '0;
        evictions_seen = '0;
        reclaims_seen = '0;
      end
      default: ;
    endcase
    if (rq.mode inside {MODE_GET, MODE_CONTAINS, MODE_PUT, MODE_REMOVE, MODE_APPEND}) begin
      j = find_slot(rq.seq_id);
      if (j >= 0) begin
        rs.entry_key_count = slot_keys[j];
        rs.entry_value_count = slot_vals[j];
      end
    end
    rs.entries_used = 5'(live_slots());
    rs.memory_used = (held_elems > longint'(MEM_OUT_MAX)) ? MEM_OUT_MAX
                                                          : held_elems[MEM_OUT_W-1:0];
    rs.evicted_now = 5'(nev);
    rs.hit_total = hits_seen;
    rs.miss_total = misses_seen;
    rs.eviction_total = evictions_seen;
    rs.reclaim_total = reclaims_seen;
    return rs;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    error_count++;
    $display("MISMATCH result %0d field %s: got 0x%0h expected 0x%0h",
             results_checked, field, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Request driver: feeds pending requests, predicting each one as it is taken.
  int         in_gap;
  cache_req_t in_cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) expected_rsps.insert(expected_rsps.size(), predict_lookup(in_cur));
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_cur = pending_reqs[0];
        pending_reqs.delete(0);
        in_if.mode <= in_cur.mode;
        in_if.seq_id <= in_cur.seq_id;
        in_if.key_count <= in_cur.key_count;
        in_if.value_count <= in_cur.value_count;
        in_if.valid <= 1'b1;
        in_gap = no_gaps ? 0 : $urandom_range(0, 4);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Result monitor and ready generator.
  int         out_wait;
  cache_rsp_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.hit, out_if.entry_key_count, out_if.entry_value_count,
                out_if.entries_used, out_if.memory_used, out_if.evicted_now,
                out_if.hit_total, out_if.miss_total, out_if.eviction_total,
                out_if.reclaim_total};
        if (expected_rsps.size() == 0) begin
          error_count++;
          $display("UNEXPECTED result %0d with no request outstanding", results_checked);
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.entry_key_count !== want.entry_key_count)
            report_mismatch("entry_key_count", got.entry_key_count, want.entry_key_count);
          if (got.entry_value_count !== want.entry_value_count)
            report_mismatch("entry_value_count", got.entry_value_count,
                            want.entry_value_count);
          if (got.entries_used !== want.entries_used)
            report_mismatch("entries_used", got.entries_used, want.entries_used);
          if (got.memory_used !== want.memory_used)
            report_mismatch("memory_used", got.memory_used, want.memory_used);
          if (got.evicted_now !== want.evicted_now)
            report_mismatch("evicted_now", got.evicted_now, want.evicted_now);
          if (got.hit_total !== want.hit_total)
            report_mismatch("hit_total", got.hit_total, want.hit_total);
          if (got.miss_total !== want.miss_total)
            report_mismatch("miss_total", got.miss_total, want.miss_total);
          if (got.eviction_total !== want.eviction_total)
            report_mismatch("eviction_total", got.eviction_total, want.eviction_total);
          if (got.reclaim_total !== want.reclaim_total)
            report_mismatch("reclaim_total", got.reclaim_total, want.reclaim_total);
        end
        results_checked++;
        out_wait = no_gaps ? 0 : $urandom_range(0, 4);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_if.ready <= (out_wait == 0) && (hold_left == 0) && !hold_go;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_MAX_ENTRIES) entry_limit_reg = value[4:0];
    else budget_mb_reg = value;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_if.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic void queue_req(mode_t m, logic [31:0] id, logic [28:0] k, logic [28:0] v);
    cache_req_t rq;
    rq = '{m, id, k, v};
    pending_reqs.insert(pending_reqs.size(), rq);
  endfunction

  function automatic logic [28:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 29'($urandom_range(0, 40000));
    if (r < 88) return 29'($urandom_range(40000, 400000));
    if (r < 97) return 29'($urandom);
    return (r == 97) ? COUNT_MAX : 29'h1000_0000;
  endfunction

  function automatic void queue_random();
    int r;
    mode_t m;
    logic [31:0] id;
    r = $urandom_range(0, 99);
    if (r < 25) m = MODE_GET;
    else if (r < 35) m = MODE_CONTAINS;
    else if (r < 66) m = MODE_PUT;
    else if (r < 77) m = MODE_REMOVE;
    else if (r < 91) m = MODE_APPEND;
    else if (r < 94) m = MODE_CLEAR;
    else if (r < 97) m = MODE_STATS;
    else m = MODE_NOP;
    id = ($urandom_range(0, 99) < 88) ? id_pool[$urandom_range(0, 19)] : $urandom;
    queue_req(m, id, pick_count(), pick_count());
  endfunction

  logic [11:0] entry_cfgs  [8] = '{12'd16, 12'd1, 12'd4, 12'd0, 12'hFFF, 12'd16, 12'd3, 12'd8};
  logic [11:0] budget_cfgs [8] = '{12'd0, 12'd0, 12'd1, 12'd4095, 12'd2, 12'd1, 12'd0, 12'd3};

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_GET;
    in_if.seq_id = '0;
    in_if.key_count = '0;
    in_if.value_count = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MAX_ENTRIES;
    cfg_if.data = '0;
    hold_go = 1'b0;
    no_gaps = 1'b0;
    error_count = 0;
    results_checked = 0;
    budget_evictions = 0;
    clear_table();
    hits_seen = '0;
    misses_seen = '0;
    evictions_seen = '0;
    reclaims_seen = '0;
    entry_limit_reg = MAX_ENTRIES_RESET;
    budget_mb_reg = '0;
    foreach (id_pool[i]) id_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed opening: extremes, every command and the corner behaviours.
    queue_req(MODE_GET, 32'h0, '0, '0);
    queue_req(MODE_PUT, 32'h0, COUNT_MAX, COUNT_MAX);
    queue_req(MODE_PUT, 32'hFFFF_FFFF, 29'd5, 29'd7);
    queue_req(MODE_GET, 32'hFFFF_FFFF, '0, '0);
    queue_req(MODE_CONTAINS, 32'h0, '0, '0);
    queue_req(MODE_CONTAINS, 32'h1234_5678, '0, '0);
    queue_req(MODE_APPEND, 32'h0, 29'd100, 29'd3);
    queue_req(MODE_APPEND, 32'hFFFF_FFFF, 29'd10, COUNT_MAX);
    queue_req(MODE_APPEND, 32'h1234_5678, 29'd10, 29'd1);
    queue_req(MODE_PUT, 32'hFFFF_FFFF, 29'd1, 29'd2);
    queue_req(MODE_REMOVE, 32'h1234_5678, '0, '0);
    queue_req(MODE_REMOVE, 32'h0, '0, '0);
    queue_req(MODE_GET, 32'h0, '0, '0);
    queue_req(MODE_NOP, 32'hFFFF_FFFF, COUNT_MAX, COUNT_MAX);
    queue_req(MODE_STATS, 32'h0, '0, '0);
    queue_req(MODE_PUT, 32'hA5A5_5A5A, 29'h0AAA_AAAA, 29'h1555_5555);
    queue_req(MODE_CLEAR, 32'hFFFF_FFFF, '0, '0);
    queue_req(MODE_GET, 32'hFFFF_FFFF, '0, '0);
    for (int i = 0; i < 18; i++) queue_req(MODE_PUT, 32'(i), 29'(i), 29'(2 * i));
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_MAX_ENTRIES, entry_cfgs[p]);
      write_reg(CFG_MAX_MEMORY_MB, budget_cfgs[p]);
      no_gaps = (p == 1) || (p == 5);
      for (int n = 0; n < 120; n++) queue_random();
      if (p == 2) begin
        // Hold the results back while requests keep arriving, so the input stalls.
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (p == 3) drain();
      for (int n = 0; n < 110; n++) queue_random();
      drain();
    end

    $display("Checked %0d results over 8 register settings; %0d budget-forced evictions seen.",
             results_checked, budget_evictions);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d requests still outstanding.", expected_rsps.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
